// ===== hw/rtl/gca_pkg.sv =====
// ----------------------------------------------------------------------------
// gca_pkg
// Shared types and constants for the glyph coverage blender.
// ----------------------------------------------------------------------------
package gca_pkg;

	typedef enum logic [1:0] {
		FMT_ARGB8888 = 2'd0,
		FMT_RGB888   = 2'd1,
		FMT_ARGB4444 = 2'd2,
		FMT_RGB565   = 2'd3
	} fmt_t;

	localparam logic [1:0] CFG_TEXT_COLOR    = 2'd0;
	localparam logic [1:0] CFG_PIXEL_FORMAT  = 2'd1;
	localparam logic [1:0] CFG_COVERAGE_MODE = 2'd2;

	localparam logic MODE_MONO = 1'b0;
	localparam logic MODE_GRAY = 1'b1;

	localparam logic [7:0] COV_MAX   = 8'hFF;
	localparam logic [7:0] ALPHA_MAX = 8'hFF;

	// four channel lanes, zero-extended to 8 bits
	typedef logic [3:0][7:0]  lanes_t;
	// per-lane weighted sums, at most 255*255
	typedef logic [3:0][15:0] sums_t;

	typedef struct packed {
		logic        blend;
		logic        we;
		fmt_t        fmt;
		logic [31:0] bypass;
	} ctl_t;

endpackage

// ===== hw/rtl/glyph_coverage_alpha_blend.sv =====
// ----------------------------------------------------------------------------
// glyph_coverage_alpha_blend
// Per-pixel glyph coverage blender over four framebuffer formats.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one transfer per pixel, tdata = coverage then
// dest_pixel. Output stream (m_axis): one transfer per input, tdata holds
// new_pixel and tuser the write flag for the framebuffer write-back.
// Configuration: cfg_we/cfg_index/cfg_wdata write text_color (0),
// pixel_format (1) and coverage_mode (2); write only while the pipe is empty.
// Stage 1 splits channels and forms the mono or pass-through result,
// stage 2 holds the per-channel weighted sums from the 8x8 multipliers,
// stage 3 holds the divided and repacked pixel, or the pass-through one,
// that drives m_axis. One pixel per cycle goes in while the pipe moves.
// Each stage has its own valid bit and loads when the stage after it is
// empty or moving, so bubbles close up while the receiver stalls; with the
// pipe full and m_axis_tready low, s_axis_tready drops and nothing is lost.
// Reset clears the valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
module glyph_coverage_alpha_blend (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // coverage[7:0], dest_pixel[39:8]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // new_pixel[31:0]
	output logic        m_axis_tuser   // write_enable
);
	import gca_pkg::*;

	logic [31:0] text_color_q;
	fmt_t        pixel_format_q;
	logic        coverage_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q    <= '0;
			pixel_format_q  <= FMT_ARGB8888;
			coverage_mode_q <= MODE_MONO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TEXT_COLOR:    text_color_q    <= cfg_wdata;
				CFG_PIXEL_FORMAT:  pixel_format_q  <= fmt_t'(cfg_wdata[1:0]);
				CFG_COVERAGE_MODE: coverage_mode_q <= cfg_wdata[0];
				default:           ;
			endcase
		end
	end

	logic        vld_s1, vld_s2, vld_s3;
	logic        rdy_s1, rdy_s2, rdy_s3;
	logic        s_xfer;

	assign rdy_s3        = !vld_s3 || m_axis_tready;
	assign rdy_s2        = !vld_s2 || rdy_s3;
	assign rdy_s1        = !vld_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;
	assign s_xfer        = s_axis_tvalid && rdy_s1;

	// stage 0 logic
	logic [7:0]  cov_in;
	logic [31:0] dst_in;
	lanes_t      fg_lanes, bg_lanes;
	ctl_t        ctl_in;
	logic [31:0] mono_px;

	assign cov_in = s_axis_tdata[7:0];
	assign dst_in = s_axis_tdata[39:8];

	gca_chan_split u_split_fg (.pixel(text_color_q), .fmt(pixel_format_q), .lanes(fg_lanes));
	gca_chan_split u_split_bg (.pixel(dst_in), .fmt(pixel_format_q), .lanes(bg_lanes));

	always_comb begin
		unique case (pixel_format_q)
			FMT_ARGB8888:             mono_px = text_color_q;
			FMT_RGB888:               mono_px = {8'd0, text_color_q[23:0]};
			FMT_ARGB4444, FMT_RGB565: mono_px = {16'd0, text_color_q[15:0]};
		endcase
	end

	always_comb begin
		ctl_in.we     = (cov_in != 8'd0);
		ctl_in.blend  = ctl_in.we && (coverage_mode_q == MODE_GRAY);
		ctl_in.fmt    = pixel_format_q;
		ctl_in.bypass = ctl_in.we ? mono_px : dst_in;
	end

	// stage 1
	logic [7:0] cov_s1, inv_s1;
	lanes_t     fg_s1, bg_s1;
	ctl_t       ctl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			cov_s1 <= cov_in;
			inv_s1 <= COV_MAX - cov_in;
			fg_s1  <= fg_lanes;
			bg_s1  <= bg_lanes;
			ctl_s1 <= ctl_in;
		end
	end

	// stage 2
	sums_t sums_c, sums_s2;
	ctl_t  ctl_s2;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sums_c[i] = {8'd0, fg_s1[i]} * {8'd0, cov_s1}
			          + {8'd0, bg_s1[i]} * {8'd0, inv_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			sums_s2 <= sums_c;
			ctl_s2  <= ctl_s1;
		end
	end

	// stage 3
	logic [31:0] blend_px;
	logic [31:0] pixel_s3;
	logic        we_s3;

	gca_chan_pack u_pack (.sums(sums_s2), .fmt(ctl_s2.fmt), .pixel(blend_px));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			pixel_s3 <= ctl_s2.blend ? blend_px : ctl_s2.bypass;
			we_s3    <= ctl_s2.we;
		end
	end

	assign m_axis_tvalid = vld_s3;
	assign m_axis_tdata  = pixel_s3;
	assign m_axis_tuser  = we_s3;

endmodule

// ===== hw/rtl/gca_chan_split.sv =====
// ----------------------------------------------------------------------------
// gca_chan_split
// Splits a pixel into right-aligned channel lanes for the given format.
// ----------------------------------------------------------------------------
module gca_chan_split (
	input  logic [31:0]   pixel,
	input  gca_pkg::fmt_t fmt,
	output gca_pkg::lanes_t lanes
);
	import gca_pkg::*;

	always_comb begin
		lanes = '0;
		unique case (fmt)
			FMT_ARGB8888, FMT_RGB888: begin
				lanes[0] = pixel[7:0];
				lanes[1] = pixel[15:8];
				lanes[2] = pixel[23:16];
			end
			FMT_ARGB4444: begin
				lanes[0] = {4'd0, pixel[3:0]};
				lanes[1] = {4'd0, pixel[7:4]};
				lanes[2] = {4'd0, pixel[11:8]};
				lanes[3] = {4'd0, pixel[15:12]};
			end
			FMT_RGB565: begin
				lanes[0] = {3'd0, pixel[4:0]};
				lanes[1] = {2'd0, pixel[10:5]};
				lanes[2] = {3'd0, pixel[15:11]};
			end
		endcase
	end

endmodule

// ===== hw/rtl/gca_chan_pack.sv =====
// ----------------------------------------------------------------------------
// gca_chan_pack
// Divides the lane sums by 255 and packs the lanes back into a pixel.
// ----------------------------------------------------------------------------
module gca_chan_pack (
	input  gca_pkg::sums_t sums,
	input  gca_pkg::fmt_t  fmt,
	output logic [31:0]    pixel
);
	import gca_pkg::*;

	lanes_t      q;
	logic [15:0] t [4];

	// floor(x/255) = (x + (x >> 8) + 1) >> 8 for x <= 255*255
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			t[i] = sums[i] + {8'd0, sums[i][15:8]} + 16'd1;
			q[i] = t[i][15:8];
		end
	end

	always_comb begin
		unique case (fmt)
			FMT_ARGB8888: pixel = {ALPHA_MAX, q[2], q[1], q[0]};
			FMT_RGB888:   pixel = {8'd0, q[2], q[1], q[0]};
			FMT_ARGB4444: pixel = {16'd0, q[3][3:0], q[2][3:0], q[1][3:0], q[0][3:0]};
			FMT_RGB565:   pixel = {16'd0, q[2][4:0], q[1][5:0], q[0][4:0]};
		endcase
	end

endmodule

// ===== hw/rtl/gca_checker.sv =====
// ----------------------------------------------------------------------------
// gca_checker
// Port-level checks on the blender's stream behavior, bound to the top level.
// ----------------------------------------------------------------------------
module gca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic s_xfer;
	assign s_xfer = s_axis_tvalid && s_axis_tready;

	// nothing comes out while in reset
	a_rst_idle: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output changed");

	// an empty or draining output stage always lets a new pixel in
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready || !m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output free");

	// with the receiver ready, a pixel transferred in must show up as valid output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_xfer, 3) && $past(m_axis_tready, 1) && $past(m_axis_tready, 2)
			&& $past(arst_n, 3) |-> m_axis_tvalid)
		else $error("result missing after three cycles");

endmodule

bind glyph_coverage_alpha_blend gca_checker u_gca_checker (.*);
